[rtl/box_average_downscale_3x3_core_macros.svh]
// Assertion helpers shared by the RTL; every check is clocked on aclk and
// disabled while aresetn is low.
`ifndef BOX_AVERAGE_DOWNSCALE_3X3_CORE_MACROS_SVH
`define BOX_AVERAGE_DOWNSCALE_3X3_CORE_MACROS_SVH

// Same-cycle implication
`define BOXDS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define BOXDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/boxds_pkg.sv]
package boxds_pkg;

    localparam int BLOCK_SIZE   = 3;
    localparam int MAX_WIDTH    = 1024;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int SUM_DEPTH    = MAX_WIDTH / BLOCK_SIZE;

    // field and register widths
    localparam int PIX_W    = 8;
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 13;
    localparam int COL_W    = 10;
    localparam int ROW_W    = 12;
    localparam int HSUM_W   = 10;
    localparam int SUM_W    = 12;
    localparam int BCOL_W   = $clog2(SUM_DEPTH);
    localparam int IDX_W    = 2;
    localparam int NCELL    = BLOCK_SIZE - 1;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = HEIGHT_W;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd768;

    // position inside a block
    localparam logic [IDX_W-1:0] IN_FIRST   = 2'd0;
    localparam logic [IDX_W-1:0] IN_PRELAST = IDX_W'(BLOCK_SIZE - 2);
    localparam logic [IDX_W-1:0] IN_LAST    = IDX_W'(BLOCK_SIZE - 1);

    // divide by 9: floor(t * 7282 / 2^16) is exact for t < 2^15
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP9 = 13'd7282;
    localparam int PROD_W = SUM_W + RECIP_W;

    typedef struct packed {
        logic [SUM_W-1:0] total;
        logic             last_row;
        logic             last_frame;
    } boxds_blk_t;

endpackage

[rtl/boxds_cell.sv]
// One tap of the horizontal window: holds a pixel, adds it to the partial
// sum coming down the chain and hands its pixel to the next cell.
module boxds_cell (
    input  logic                         aclk,
    input  logic                         shift_en,
    input  logic [boxds_pkg::PIX_W-1:0]  pix_in,
    input  logic [boxds_pkg::HSUM_W-1:0] sum_in,
    output logic [boxds_pkg::PIX_W-1:0]  pix_out,
    output logic [boxds_pkg::HSUM_W-1:0] sum_out
);
    import boxds_pkg::*;

    logic [PIX_W-1:0] pix_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            pix_reg <= pix_in;
        end
    end

    assign pix_out = pix_reg;
    assign sum_out = sum_in + HSUM_W'(pix_reg);

endmodule

[rtl/boxds_colsum.sv]
// Per-block-column partial sums: one write port, one registered read port.
module boxds_colsum (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [boxds_pkg::BCOL_W-1:0] wr_addr,
    input  logic [boxds_pkg::SUM_W-1:0]  wr_data,
    input  logic                         rd_en,
    input  logic [boxds_pkg::BCOL_W-1:0] rd_addr,
    output logic [boxds_pkg::SUM_W-1:0]  rd_data
);
    import boxds_pkg::*;

    logic [SUM_W-1:0] mem [SUM_DEPTH];
    logic [SUM_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/boxds_div9.sv]
// Output stage: block total times reciprocal of 9, held in the output register.
module boxds_div9 (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  boxds_pkg::boxds_blk_t       in_blk,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [boxds_pkg::PIX_W-1:0] out_avg,
    output logic                        out_last_row,
    output logic                        out_last_frame
);
    import boxds_pkg::*;

    logic              valid_reg;
    logic [PIX_W-1:0]  avg_reg;
    logic              last_row_reg;
    logic              last_frame_reg;
    logic [PROD_W-1:0] prod;

    assign in_ready = !valid_reg || out_ready;
    assign prod     = PROD_W'(in_blk.total) * PROD_W'(RECIP9);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            avg_reg        <= prod[RECIP_SHIFT +: PIX_W];
            last_row_reg   <= in_blk.last_row;
            last_frame_reg <= in_blk.last_frame;
        end
    end

    assign out_valid      = valid_reg;
    assign out_avg        = avg_reg;
    assign out_last_row   = last_row_reg;
    assign out_last_frame = last_frame_reg;

endmodule

[rtl/box_average_downscale_3x3_core.sv]
// 3x3 box-average downscaler. Takes one 8-bit pixel per clock in raster
// order and gives one result per complete 3x3 block (sum / 9, truncated),
// marked at the end of each block row and of the frame; partial blocks at the
// right and bottom edges give nothing. The input takes a beat every cycle and
// stalls only when both result registers are full; a result passes the block
// total register, then the divider's output register. Each pixel goes through a
// chain of two pixel cells that form the horizontal sum, and a 341 x 12 column
// store (one write, one registered read) carries partial block sums between
// rows; it needs no clearing pass and the block accepts pixels right after reset.
// Width (3..1024) and height (3..4096) are saturated to range and may be
// written only while the block is idle.
module box_average_downscale_3x3_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic                             cfg_we,
    input  logic [boxds_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [boxds_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // pixel input
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [boxds_pkg::PIX_W-1:0]      s_pixel,
    // block results
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [boxds_pkg::PIX_W-1:0]      m_block_average,
    output logic                             m_last_in_block_row,
    output logic                             m_last_in_frame
);
    import boxds_pkg::*;

    `include "box_average_downscale_3x3_core_macros.svh"

    logic [WIDTH_W-1:0]  image_width_reg;
    logic [HEIGHT_W-1:0] image_height_reg;
    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;

    logic [COL_W-1:0]  col_reg,     col_next;
    logic [ROW_W-1:0]  row_reg,     row_next;
    logic [IDX_W-1:0]  in_col_reg,  in_col_next;
    logic [IDX_W-1:0]  in_row_reg,  in_row_next;
    logic [BCOL_W-1:0] blk_col_reg, blk_col_next;

    logic                s_fire;
    logic [WIDTH_W-1:0]  col_inc;
    logic [HEIGHT_W-1:0] row_inc;
    logic [HEIGHT_W-1:0] row_base;
    logic                col_wrap, row_wrap;
    logic                col_fits, col_last, row_fits, row_last;
    logic                blk_ok, emit, store_wr;
    logic [HSUM_W-1:0]   hsum;
    logic [SUM_W-1:0]    rd_data;
    logic [SUM_W-1:0]    total;

    logic [PIX_W-1:0]  cell_pix [NCELL+1];
    logic [HSUM_W-1:0] cell_sum [NCELL+1];

    logic       st1_valid_reg;
    boxds_blk_t st1_reg;
    logic       st1_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // saturate sizes to the supported range
    always_comb begin
        if (image_width_reg < WIDTH_W'(BLOCK_SIZE)) begin
            w_eff = WIDTH_W'(BLOCK_SIZE);
        end else if (image_width_reg > WIDTH_W'(MAX_WIDTH)) begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end else begin
            w_eff = image_width_reg;
        end
        if (image_height_reg < HEIGHT_W'(BLOCK_SIZE)) begin
            h_eff = HEIGHT_W'(BLOCK_SIZE);
        end else if (image_height_reg > HEIGHT_W'(HEIGHT_LIMIT)) begin
            h_eff = HEIGHT_W'(HEIGHT_LIMIT);
        end else begin
            h_eff = image_height_reg;
        end
    end

    assign s_fire = s_valid && s_ready;

    // horizontal window: chain of pixel cells
    assign cell_pix[0] = s_pixel;
    assign cell_sum[0] = HSUM_W'(s_pixel);

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        boxds_cell u_cell (
            .aclk     (aclk),
            .shift_en (s_fire),
            .pix_in   (cell_pix[i]),
            .sum_in   (cell_sum[i]),
            .pix_out  (cell_pix[i+1]),
            .sum_out  (cell_sum[i+1])
        );
    end

    assign hsum = cell_sum[NCELL];

    // block position checks; at a block's last column col + 1 = 3 * (bc + 1)
    assign col_inc  = WIDTH_W'(col_reg) + 1'b1;
    assign row_inc  = HEIGHT_W'(row_reg) + 1'b1;
    assign col_wrap = col_inc >= w_eff;
    assign row_wrap = row_inc >= h_eff;
    assign row_base = HEIGHT_W'(row_reg) - HEIGHT_W'(in_row_reg);
    assign col_fits = col_inc <= w_eff;
    assign col_last = (col_inc + WIDTH_W'(BLOCK_SIZE)) > w_eff;
    assign row_fits = (row_base + HEIGHT_W'(BLOCK_SIZE)) <= h_eff;
    assign row_last = (row_base + HEIGHT_W'(2 * BLOCK_SIZE)) > h_eff;

    assign blk_ok   = (in_col_reg == IN_LAST) && col_fits && row_fits;
    assign emit     = blk_ok && (in_row_reg == IN_LAST);
    assign store_wr = s_fire && blk_ok && (in_row_reg != IN_LAST);
    assign total    = SUM_W'(hsum) + ((in_row_reg != IN_FIRST) ? rd_data : '0);

    // column store: read one beat ahead of the block's last column
    boxds_colsum u_colsum (
        .aclk    (aclk),
        .wr_en   (store_wr),
        .wr_addr (blk_col_reg),
        .wr_data (total),
        .rd_en   (s_fire && (in_col_reg == IN_PRELAST)),
        .rd_addr (blk_col_reg),
        .rd_data (rd_data)
    );

    // raster counters
    always_comb begin
        col_next     = col_reg;
        row_next     = row_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        blk_col_next = blk_col_reg;
        if (col_wrap) begin
            col_next     = '0;
            in_col_next  = IN_FIRST;
            blk_col_next = '0;
            if (row_wrap) begin
                row_next    = '0;
                in_row_next = IN_FIRST;
            end else begin
                row_next    = row_inc[ROW_W-1:0];
                in_row_next = (in_row_reg == IN_LAST) ? IN_FIRST : in_row_reg + 1'b1;
            end
        end else begin
            col_next = col_inc[COL_W-1:0];
            if (in_col_reg == IN_LAST) begin
                in_col_next  = IN_FIRST;
                blk_col_next = blk_col_reg + 1'b1;
            end else begin
                in_col_next = in_col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            in_col_reg  <= IN_FIRST;
            in_row_reg  <= IN_FIRST;
            blk_col_reg <= '0;
        end else if (s_fire) begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            blk_col_reg <= blk_col_next;
        end
    end

    // block total stage
    assign s_ready = !st1_valid_reg || st1_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            st1_valid_reg <= s_fire && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && emit) begin
            st1_reg.total      <= total;
            st1_reg.last_row   <= col_last;
            st1_reg.last_frame <= col_last && row_last;
        end
    end

    // divide and output register
    boxds_div9 u_div9 (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (st1_valid_reg),
        .in_ready       (st1_ready),
        .in_blk         (st1_reg),
        .out_valid      (m_valid),
        .out_ready      (m_ready),
        .out_avg        (m_block_average),
        .out_last_row   (m_last_in_block_row),
        .out_last_frame (m_last_in_frame)
    );

    `BOXDS_ASSERT_IMPL(a_col_zero_aligned, col_reg == '0, in_col_reg == IN_FIRST && blk_col_reg == '0, "column sub-counters out of step")
    `BOXDS_ASSERT_IMPL(a_frame_end_is_row_end, st1_valid_reg && st1_reg.last_frame, st1_reg.last_row, "frame end without block row end")
    `BOXDS_ASSERT_NEXT(a_block_needs_beat, !s_fire, !$rose(st1_valid_reg), "block result without a pixel beat")
    `BOXDS_ASSERT_NEXT(a_block_at_last_col, s_fire && in_col_reg != IN_LAST, !$rose(st1_valid_reg), "block result off a block's last column")

endmodule
